// ----- rtl/slid_pkg.sv -----
// Package for the sorted list insert/delete unit.
// Holds the table size, the request/result transaction types and the status codes.
// Depends on nothing.
package slid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int TOTAL_W  = 5;
    localparam int DATA_W   = 32;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [DATA_W-1:0]  item_index;
        logic signed [DATA_W-1:0]  item_value;
    } t_req;

    typedef struct packed {
        t_status              op_status;
        logic [TOTAL_W-1:0]   entry_total;
        logic                 is_empty;
    } t_res;

    // One table entry as held in a cell.
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [DATA_W-1:0]        tag;
    } t_entry;

    // Per-cell control from the top level.
    typedef struct packed {
        logic occ;     // cell holds a live entry
        logic at_end;  // cell is the first free slot
        logic do_ins;  // accepted insert that fits
        logic do_del;  // accepted delete
    } t_cell_ctl;

endpackage

// ----- rtl/slid_cell.sv -----
// One slot of the sorted table: compares its entry with the request key and
// shifts data from its left or right neighbor. Depends on slid_pkg.
module slid_cell
    import slid_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0]  i_key,
    input  logic [DATA_W-1:0]         i_tag,
    input  t_entry                    i_left,
    input  logic                      i_left_gt,
    input  t_entry                    i_right,
    input  logic                      i_found,
    output t_entry                    o_entry,
    output logic                      o_gt,
    output logic                      o_found
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_eq;

    assign o_gt    = i_ctl.occ && ($signed(r_entry.value) > i_key);
    assign w_eq    = i_ctl.occ && (r_entry.value == i_key);
    assign o_found = i_found || w_eq;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_ins) begin
            // Cells past the insert point move one slot toward the tail.
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_ctl.at_end) begin
                n_entry.value = i_key;
                n_entry.tag   = i_tag;
            end
        end else if (i_ctl.do_del) begin
            // From the first match on, every cell takes its right neighbor.
            if (o_found) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ----- rtl/sorted_list_insert_delete_unit.sv -----
// A result strobes in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, the compare and shift
// across the row of cells completes in the accepting cycle.
// Reset: synchronous, active low; clears the entry count and the result strobe.
// The receiver cannot stall; each result is shown for exactly one cycle.
module sorted_list_insert_delete_unit
    import slid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_res_valid,
    output t_res  o_res
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_res_valid;
    t_res             r_res;
    t_res             n_res;

    logic             w_accept;
    logic             w_full;
    logic             w_do_ins;
    logic             w_do_del;

    t_entry           w_entry [CAPACITY];
    logic             w_gt    [CAPACITY];
    logic             w_found [CAPACITY+1];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(CAPACITY));
    assign w_do_ins = w_accept && (i_req.req_type == REQ_INSERT) && !w_full;
    assign w_do_del = w_accept && (i_req.req_type == REQ_DELETE);
    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_cell_ctl w_ctl;
        t_entry    w_left;
        t_entry    w_right;
        logic      w_left_gt;

        assign w_ctl.occ    = (CNT_W'(g) < r_count);
        assign w_ctl.at_end = (CNT_W'(g) == r_count);
        assign w_ctl.do_ins = w_do_ins;
        assign w_ctl.do_del = w_do_del;

        if (g == 0) begin : g_head
            assign w_left    = w_entry[g];
            assign w_left_gt = 1'b0;
        end else begin : g_body
            assign w_left    = w_entry[g-1];
            assign w_left_gt = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_mid
            assign w_right = w_entry[g+1];
        end

        slid_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_key     (i_req.item_value),
            .i_tag     (i_req.item_index),
            .i_left    (w_left),
            .i_left_gt (w_left_gt),
            .i_right   (w_right),
            .i_found   (w_found[g]),
            .o_entry   (w_entry[g]),
            .o_gt      (w_gt[g]),
            .o_found   (w_found[g+1])
        );
    end

    always_comb begin
        n_count = r_count;
        n_res.op_status = ST_INSERTED;
        if (i_req.req_type == REQ_INSERT) begin
            if (w_full) begin
                n_res.op_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_found[CAPACITY]) begin
                n_res.op_status = ST_REMOVED;
                n_count = r_count - CNT_W'(1);
            end else begin
                n_res.op_status = ST_NOT_FOUND;
            end
        end
        n_res.entry_total = TOTAL_W'(n_count);
        n_res.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/slid_checker.sv -----
// Port-level checker for the sorted list insert/delete unit, bound to the top.
// Depends on slid_pkg and sorted_list_insert_delete_unit.
module slid_checker
    import slid_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  start,
    input logic  busy,
    input logic  o_res_valid,
    input t_res  o_res
);

    // Every accepted transaction gives a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_res_valid)
        else $error("result missing after accepted request");

    // No result appears without a request in the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_res_valid)
        else $error("result without request");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.is_empty == (o_res.entry_total == '0)))
        else $error("empty flag disagrees with entry total");

    // Back-to-back results: an insert adds one entry, a refused request adds none.
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && $past(o_res_valid) && (o_res.op_status == ST_INSERTED))
        |-> (o_res.entry_total == TOTAL_W'($past(o_res.entry_total) + TOTAL_W'(1))))
        else $error("insert did not grow the table by one");

    a_refused_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && $past(o_res_valid)
         && ((o_res.op_status == ST_FULL) || (o_res.op_status == ST_NOT_FOUND)))
        |-> $stable(o_res.entry_total))
        else $error("refused request changed the entry total");

endmodule

bind sorted_list_insert_delete_unit slid_checker u_slid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the sorted list insert/delete unit.
// A directed table and a random phase are checked against a behavioral table model.
// Depends on slid_pkg and sorted_list_insert_delete_unit from the rtl folder.
module tb_top;
    import slid_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    localparam int CYCLE_LIMIT  = 20000;

    typedef struct {
        t_res result;
        bit   has_known;
        t_res known;
    } t_expect;

    typedef struct {
        t_req req;
        bit   has_known;
        t_res known;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_res_valid;
    t_res o_res;

    // Known result that travels with the request on the bus.
    logic sent_has_known;
    t_res sent_known;

    // Behavioral copy of the sorted table.
    logic signed [DATA_W-1:0] list_value [CAPACITY];
    logic [DATA_W-1:0]        list_tag [CAPACITY];
    int                       list_count = 0;

    t_expect pending_results[$];
    t_row    directed_rows[$];
    int      error_count = 0;
    int      cycle_count = 0;

    sorted_list_insert_delete_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_res_valid(o_res_valid),
        .o_res      (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Applies one request to the table copy and returns the result it should produce.
    function automatic t_res apply_to_list(t_req r);
        int   pos;
        t_res res;
        pos = 0;
        if (r.req_type == REQ_INSERT) begin
            if (list_count >= CAPACITY) begin
                res.op_status = ST_FULL;
            end else begin
                // Equal values stay in arrival order, so the new entry goes after them.
                while (pos < list_count && list_value[pos] <= r.item_value) pos++;
                for (int i = list_count; i > pos; i--) begin
                    list_value[i] = list_value[i-1];
                    list_tag[i]   = list_tag[i-1];
                end
                list_value[pos] = r.item_value;
                list_tag[pos]   = r.item_index;
                list_count++;
                res.op_status = ST_INSERTED;
            end
        end else begin
            while (pos < list_count && list_value[pos] != r.item_value) pos++;
            if (pos >= list_count) begin
                res.op_status = ST_NOT_FOUND;
            end else begin
                for (int i = pos; i + 1 < list_count; i++) begin
                    list_value[i] = list_value[i+1];
                    list_tag[i]   = list_tag[i+1];
                end
                list_count--;
                res.op_status = ST_REMOVED;
            end
        end
        res.entry_total = TOTAL_W'(list_count);
        res.is_empty    = (list_count == 0);
        return res;
    endfunction

    function automatic void compare_result(t_res exp_res, t_res act, string source);
        if (act.op_status !== exp_res.op_status) begin
            $display("%0t: op_status mismatch (%s): expected %s, actual %0d",
                     $time, source, exp_res.op_status.name(), act.op_status);
            error_count++;
        end
        if (act.entry_total !== exp_res.entry_total) begin
            $display("%0t: entry_total mismatch (%s): expected %0d, actual %0d",
                     $time, source, exp_res.entry_total, act.entry_total);
            error_count++;
        end
        if (act.is_empty !== exp_res.is_empty) begin
            $display("%0t: is_empty mismatch (%s): expected %0b, actual %0b",
                     $time, source, exp_res.is_empty, act.is_empty);
            error_count++;
        end
    endfunction

    // Results are checked before the transaction of the same edge is recorded,
    // since a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n) begin
            if (o_res_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %p", $time, o_res);
                    error_count++;
                end else begin
                    e = pending_results.pop_front();
                    compare_result(e.result, o_res, "predicted");
                    if (e.has_known) compare_result(e.known, o_res, "table");
                end
            end
            if (start && !busy) begin
                e.result    = apply_to_list(i_req);
                e.has_known = sent_has_known;
                e.known     = sent_known;
                pending_results.push_back(e);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic t_row make_row(t_req_type kind, logic [DATA_W-1:0] tag,
                                      logic [DATA_W-1:0] value, t_status st, int total);
        t_row row;
        row.req.req_type          = kind;
        row.req.item_index        = tag;
        row.req.item_value        = value;
        row.has_known             = 1'b1;
        row.known.op_status       = st;
        row.known.entry_total     = TOTAL_W'(total);
        row.known.is_empty        = (total == 0);
        return row;
    endfunction

    // Mix of extremes, a narrow band that makes duplicates likely, and full-range values.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4: return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default:    return $urandom;
        endcase
    endfunction

    task automatic send_request(t_req r, bit has_known, t_res known, bit gaps);
        if (gaps && $urandom_range(0, 99) < 20) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req          <= r;
        sent_has_known <= has_known;
        sent_known     <= known;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        t_req r;
        t_res none;
        bit   filling;
        none           = '0;
        filling        = 1'b1;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_req          <= '0;
        sent_has_known <= 1'b0;
        sent_known     <= '0;

        // Empty table, extremes, equal values, misses, filling to capacity and a refused insert.
        directed_rows.push_back(make_row(REQ_DELETE, 32'd9, 32'd5, ST_NOT_FOUND, 0));
        directed_rows.push_back(make_row(REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         ST_INSERTED, 1));
        directed_rows.push_back(make_row(REQ_INSERT, 32'h8000_0000, 32'h8000_0000,
                                         ST_INSERTED, 2));
        directed_rows.push_back(make_row(REQ_INSERT, 32'd0, 32'd0, ST_INSERTED, 3));
        directed_rows.push_back(make_row(REQ_INSERT, 32'hFFFF_FFFF, 32'd0, ST_INSERTED, 4));
        directed_rows.push_back(make_row(REQ_DELETE, 32'd0, 32'd0, ST_REMOVED, 3));
        directed_rows.push_back(make_row(REQ_DELETE, 32'd0, 32'd1, ST_NOT_FOUND, 3));
        directed_rows.push_back(make_row(REQ_DELETE, 32'd0, 32'hFFFF_FFFF, ST_NOT_FOUND, 3));
        for (int k = 0; k < CAPACITY - 3; k++)
            directed_rows.push_back(make_row(REQ_INSERT, DATA_W'(k), DATA_W'(k * 37 - 200),
                                             ST_INSERTED, k + 4));
        directed_rows.push_back(make_row(REQ_INSERT, 32'd1, 32'd0, ST_FULL, CAPACITY));
        directed_rows.push_back(make_row(REQ_DELETE, 32'd0, 32'h8000_0000, ST_REMOVED,
                                         CAPACITY - 1));
        directed_rows.push_back(make_row(REQ_DELETE, 32'd0, 32'h7FFF_FFFF, ST_REMOVED,
                                         CAPACITY - 2));
        directed_rows.push_back(make_row(REQ_INSERT, 32'h5A5A_A5A5, 32'h7FFF_FFFF,
                                         ST_INSERTED, CAPACITY - 1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            send_request(directed_rows[n].req, directed_rows[n].has_known,
                         directed_rows[n].known, 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) begin
                // Let the unit drain completely before carrying on.
                start <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            // Sweep the table between empty and full so both ends are hit repeatedly.
            if (list_count >= CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (list_count == 0) filling = 1'b1;
            r.item_index = $urandom;
            if ($urandom_range(0, 99) < (filling ? 80 : 20)) begin
                r.req_type   = REQ_INSERT;
                r.item_value = pick_value();
            end else begin
                r.req_type = REQ_DELETE;
                if (list_count > 0 && $urandom_range(0, 99) < 70)
                    r.item_value = list_value[$urandom_range(0, list_count - 1)];
                else
                    r.item_value = pick_value();
            end
            send_request(r, 1'b0, none, !(n >= 200 && n < 320));
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
